// ===== hw/rtl/gbfq_pkg.sv =====
// Shared constants, codes and types for the grid BFS frontier queue unit.
// No dependencies; used by the top level and by the port checker.
package gbfq_pkg;

    // Sizing of the cell map and the frontier queue.
    localparam int MAX_SIDE     = 64;
    localparam int QUEUE_DEPTH  = 1024;
    localparam int PAYLOAD_BITS = 16;
    localparam int NEIGH_SLOTS  = 4;

    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int MAP_AW  = $clog2(CELLS);
    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = $clog2(NEIGH_SLOTS);

    // Fixed field widths.
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int CELL_W    = 8;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] SIDE_MAX = DIM_W'(MAX_SIDE);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEIGH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SCAN  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_RD,
        ST_NEIGH,
        ST_SCAN_E,
        ST_SCAN_M,
        ST_POST
    } state_t;

    // One frontier queue entry.
    typedef struct packed {
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [CELL_W-1:0]       read_value;
        logic                    found;
        logic                    done;
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic [PAYLOAD_BITS-1:0] payload;
    } result_t;

endpackage

// ===== hw/rtl/grid_bfs_frontier_queue_unit.sv =====
// Grid BFS frontier queue unit: cell map memory, queue memory and request sequencer.
// Depends on gbfq_pkg.
//
// The unit keeps a 64 x 64 map of 8-bit cells (0 means free) and a frontier
// queue of up to 1024 entries, each in its own single-port-write memory with a
// registered read. After reset the unit sweeps all 4096 map cells to zero, one
// cell per cycle; no request is taken during the sweep, while configuration
// writes are. One request is handled at a time. A write, push, clear, ignored
// request or scan-done step loads its result into the output register directly;
// a cell read first reads the map (unless the cell is out of range), a scan step
// reads the queue, then the map (unless the entry lies outside the grid), then
// marks the cell visited if it is free, and a neighbor push (when the queue has
// room for all four) writes each in-grid neighbor to the queue memory, which
// takes one entry per cycle. The next request is accepted in the cycle after
// its predecessor's result is loaded, even while that result waits in the
// output register.
module grid_bfs_frontier_queue_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [gbfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbfq_pkg::DIM_W-1:0]           cfg_wdata,
    // Request channel.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gbfq_pkg::REQ_W-1:0]           req_type,
    input  logic [gbfq_pkg::COORD_W-1:0]         col,
    input  logic [gbfq_pkg::COORD_W-1:0]         row,
    input  logic [gbfq_pkg::CELL_W-1:0]          cell_data,
    input  logic [gbfq_pkg::PAYLOAD_BITS-1:0]    payload,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gbfq_pkg::STATUS_W-1:0]        status,
    output logic [gbfq_pkg::CELL_W-1:0]          read_value,
    output logic                                 found,
    output logic                                 done_res,
    output logic [gbfq_pkg::COORD_W-1:0]         out_col,
    output logic [gbfq_pkg::COORD_W-1:0]         out_row,
    output logic [gbfq_pkg::PAYLOAD_BITS-1:0]    out_payload,
    output logic                                 queue_empty
);

    localparam int PROD_W   = gbfq_pkg::COORD_W + gbfq_pkg::DIM_W;
    localparam int CNT_W    = gbfq_pkg::CNT_W;
    localparam int CHK_W    = gbfq_pkg::CNT_W + 1;
    localparam int DIM_W    = gbfq_pkg::DIM_W;
    localparam int CELL_W   = gbfq_pkg::CELL_W;
    localparam int SLOT_W   = gbfq_pkg::SLOT_W;

    localparam logic [CHK_W-1:0]  DEPTH_CHK  = CHK_W'(gbfq_pkg::QUEUE_DEPTH);
    localparam logic [CHK_W-1:0]  SLOTS_CHK  = CHK_W'(gbfq_pkg::NEIGH_SLOTS);
    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(gbfq_pkg::QUEUE_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(gbfq_pkg::NEIGH_SLOTS - 1);

    // Control registers.
    gbfq_pkg::state_t                   state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   cursor_reg, cursor_next;
    logic [SLOT_W-1:0]                  slot_reg, slot_next;
    logic [gbfq_pkg::MAP_AW-1:0]        clr_reg, clr_next;
    logic [DIM_W-1:0]                   grid_w_reg, grid_h_reg;
    logic                               out_valid_reg, out_valid_next;

    // Data registers.
    logic [gbfq_pkg::COORD_W-1:0]       lat_col_reg, lat_col_next;
    logic [gbfq_pkg::COORD_W-1:0]       lat_row_reg, lat_row_next;
    logic [gbfq_pkg::PAYLOAD_BITS-1:0]  lat_tag_reg, lat_tag_next;
    logic [gbfq_pkg::MAP_AW-1:0]        idx_reg, idx_next;
    gbfq_pkg::result_t                  res_reg, res_next;
    gbfq_pkg::result_t                  out_res_reg;
    logic                               out_qempty_reg;
    logic                               load_out;

    // Memories and their ports.
    logic [CELL_W-1:0]                  map_mem [gbfq_pkg::CELLS];
    gbfq_pkg::entry_t                   ent_mem [gbfq_pkg::QUEUE_DEPTH];
    logic                               map_we, map_re;
    logic [gbfq_pkg::MAP_AW-1:0]        map_waddr;
    logic [CELL_W-1:0]                  map_wdata;
    logic [CELL_W-1:0]                  map_rdata_reg;
    logic                               ent_we, ent_re;
    logic [gbfq_pkg::QADDR_W-1:0]       ent_waddr, ent_raddr;
    gbfq_pkg::entry_t                   ent_wdata;
    gbfq_pkg::entry_t                   ent_rdata_reg;

    // Effective grid size and map index.
    logic [DIM_W-1:0]                   eff_w, eff_h;
    logic [gbfq_pkg::COORD_W-1:0]       idx_col, idx_row;
    logic [PROD_W-1:0]                  idx_full;
    logic [gbfq_pkg::MAP_AW-1:0]        map_idx;

    function automatic logic in_grid(
        input logic [gbfq_pkg::COORD_W-1:0] c,
        input logic [gbfq_pkg::COORD_W-1:0] r,
        input logic [DIM_W-1:0]             w,
        input logic [DIM_W-1:0]             h
    );
        return ({1'b0, c} < w) && ({1'b0, r} < h);
    endfunction

    // Register values above the map side are used as the map side.
    assign eff_w = (grid_w_reg > gbfq_pkg::SIDE_MAX) ? gbfq_pkg::SIDE_MAX : grid_w_reg;
    assign eff_h = (grid_h_reg > gbfq_pkg::SIDE_MAX) ? gbfq_pkg::SIDE_MAX : grid_h_reg;

    // Cell index is row * width + col; during a scan the coordinates come from the queue.
    assign idx_col  = (state_reg == gbfq_pkg::ST_SCAN_E) ? ent_rdata_reg.col : col;
    assign idx_row  = (state_reg == gbfq_pkg::ST_SCAN_E) ? ent_rdata_reg.row : row;
    assign idx_full = PROD_W'(idx_row) * PROD_W'(eff_w) + PROD_W'(idx_col);
    assign map_idx  = idx_full[gbfq_pkg::MAP_AW-1:0];

    // Sequencer: next state, memory controls and result building.
    always_comb
    begin
        gbfq_pkg::entry_t nb;
        logic             nb_ok;

        state_next   = state_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        lat_col_next = lat_col_reg;
        lat_row_next = lat_row_reg;
        lat_tag_next = lat_tag_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        map_we       = 1'b0;
        map_waddr    = map_idx;
        map_wdata    = '0;
        map_re       = 1'b0;
        ent_we       = 1'b0;
        ent_waddr    = count_reg[gbfq_pkg::QADDR_W-1:0];
        ent_wdata    = '0;
        ent_re       = 1'b0;
        ent_raddr    = cursor_reg[gbfq_pkg::QADDR_W-1:0];
        load_out     = 1'b0;
        in_ready     = 1'b0;
        nb           = '0;
        nb_ok        = 1'b0;

        unique case (state_reg)
            gbfq_pkg::ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = gbfq_pkg::ST_IDLE;
                end
            end

            gbfq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next     = '0;
                    lat_col_next = col;
                    lat_row_next = row;
                    lat_tag_next = payload;
                    slot_next    = '0;
                    state_next   = gbfq_pkg::ST_POST;
                    unique case (req_type)
                        gbfq_pkg::REQ_WRITE:
                        begin
                            if (in_grid(col, row, eff_w, eff_h))
                            begin
                                map_we              = 1'b1;
                                map_wdata           = cell_data;
                                res_next.read_value = cell_data;
                            end
                            else
                            begin
                                res_next.status = gbfq_pkg::STATUS_RANGE;
                            end
                        end
                        gbfq_pkg::REQ_READ:
                        begin
                            if (in_grid(col, row, eff_w, eff_h))
                            begin
                                map_re     = 1'b1;
                                state_next = gbfq_pkg::ST_MAP_RD;
                            end
                            else
                            begin
                                res_next.status = gbfq_pkg::STATUS_RANGE;
                            end
                        end
                        gbfq_pkg::REQ_PUSH:
                        begin
                            if (count_reg >= DEPTH_CNT)
                            begin
                                res_next.status = gbfq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_wdata  = '{col: col, row: row, payload: payload};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        gbfq_pkg::REQ_NEIGH:
                        begin
                            if (({1'b0, count_reg} + SLOTS_CHK) > DEPTH_CHK)
                            begin
                                res_next.status = gbfq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                state_next = gbfq_pkg::ST_NEIGH;
                            end
                        end
                        gbfq_pkg::REQ_SCAN:
                        begin
                            if (cursor_reg >= count_reg)
                            begin
                                res_next.done = 1'b1;
                                cursor_next   = '0;
                            end
                            else
                            begin
                                ent_re      = 1'b1;
                                cursor_next = cursor_reg + 1'b1;
                                state_next  = gbfq_pkg::ST_SCAN_E;
                            end
                        end
                        gbfq_pkg::REQ_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                            state_next = gbfq_pkg::ST_POST;
                        end
                    endcase
                end
            end

            gbfq_pkg::ST_MAP_RD:
            begin
                res_next.read_value = map_rdata_reg;
                state_next          = gbfq_pkg::ST_POST;
            end

            gbfq_pkg::ST_NEIGH:
            begin
                // One neighbor slot per cycle: right, left, down, up.
                case (slot_reg)
                    2'd0:
                    begin
                        nb_ok = ({1'b0, lat_col_reg} + DIM_W'(1)) < eff_w;
                        nb    = '{col: lat_col_reg + 1'b1, row: lat_row_reg,
                                  payload: lat_tag_reg};
                    end
                    2'd1:
                    begin
                        nb_ok = (lat_col_reg != '0);
                        nb    = '{col: lat_col_reg - 1'b1, row: lat_row_reg,
                                  payload: lat_tag_reg};
                    end
                    2'd2:
                    begin
                        nb_ok = ({1'b0, lat_row_reg} + DIM_W'(1)) < eff_h;
                        nb    = '{col: lat_col_reg, row: lat_row_reg + 1'b1,
                                  payload: lat_tag_reg};
                    end
                    default:
                    begin
                        nb_ok = (lat_row_reg != '0);
                        nb    = '{col: lat_col_reg, row: lat_row_reg - 1'b1,
                                  payload: lat_tag_reg};
                    end
                endcase
                if (nb_ok)
                begin
                    ent_we     = 1'b1;
                    ent_wdata  = nb;
                    count_next = count_reg + 1'b1;
                end
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = gbfq_pkg::ST_POST;
                end
            end

            gbfq_pkg::ST_SCAN_E:
            begin
                // Queue entry is here; look up its cell if it lies in the grid.
                lat_col_next = ent_rdata_reg.col;
                lat_row_next = ent_rdata_reg.row;
                lat_tag_next = ent_rdata_reg.payload;
                idx_next     = map_idx;
                if (in_grid(ent_rdata_reg.col, ent_rdata_reg.row, eff_w, eff_h))
                begin
                    map_re     = 1'b1;
                    state_next = gbfq_pkg::ST_SCAN_M;
                end
                else
                begin
                    state_next = gbfq_pkg::ST_POST;
                end
            end

            gbfq_pkg::ST_SCAN_M:
            begin
                // A free cell is marked visited and the entry is reported.
                if (map_rdata_reg == '0)
                begin
                    map_we           = 1'b1;
                    map_waddr        = idx_reg;
                    map_wdata        = CELL_W'(1);
                    res_next.found   = 1'b1;
                    res_next.col     = lat_col_reg;
                    res_next.row     = lat_row_reg;
                    res_next.payload = lat_tag_reg;
                end
                state_next = gbfq_pkg::ST_POST;
            end

            gbfq_pkg::ST_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = gbfq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gbfq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state, counters and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbfq_pkg::ST_CLEAR;
            count_reg     <= '0;
            cursor_reg    <= '0;
            slot_reg      <= '0;
            clr_reg       <= '0;
            grid_w_reg    <= '0;
            grid_h_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            slot_reg      <= slot_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gbfq_pkg::CFG_WIDTH:  grid_w_reg <= cfg_wdata;
                    gbfq_pkg::CFG_HEIGHT: grid_h_reg <= cfg_wdata;
                endcase
            end
        end
    end

    // Request latches, result and output payload.
    always_ff @(posedge clk)
    begin
        lat_col_reg <= lat_col_next;
        lat_row_reg <= lat_row_next;
        lat_tag_reg <= lat_tag_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
        if (load_out)
        begin
            out_res_reg    <= res_reg;
            out_qempty_reg <= (count_reg == '0);
        end
    end

    // Cell map memory.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_idx];
        end
    end

    // Frontier queue memory.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= ent_mem[ent_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign read_value  = out_res_reg.read_value;
    assign found       = out_res_reg.found;
    assign done_res    = out_res_reg.done;
    assign out_col     = out_res_reg.col;
    assign out_row     = out_res_reg.row;
    assign out_payload = out_res_reg.payload;
    assign queue_empty = out_qempty_reg;

endmodule

// ===== hw/rtl/gbfq_chk.sv =====
// Port-level checker for the grid BFS frontier queue unit, with its bind statement.
// Depends on gbfq_pkg and on grid_bfs_frontier_queue_unit.
module gbfq_chk
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [gbfq_pkg::STATUS_W-1:0]        status,
    input logic [gbfq_pkg::CELL_W-1:0]          read_value,
    input logic                                 found,
    input logic                                 done_res,
    input logic [gbfq_pkg::COORD_W-1:0]         out_col,
    input logic [gbfq_pkg::COORD_W-1:0]         out_row,
    input logic [gbfq_pkg::PAYLOAD_BITS-1:0]    out_payload,
    input logic                                 queue_empty
);

    // A stalled result holds its status and scan report.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
            && $stable(out_payload))
        else $error("result changed while stalled");

    // A found entry comes from a clean scan step that read no cell value.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == gbfq_pkg::STATUS_OK && !done_res
            && read_value == '0)
        else $error("found reported with a bad status or value");

    // A rewind step never reports an entry.
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !found && out_col == '0 && out_row == '0
            && out_payload == '0)
        else $error("done step carries an entry");

    // A full queue cannot be empty.
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gbfq_pkg::STATUS_FULL |-> !queue_empty)
        else $error("queue full reported with an empty queue");

endmodule

bind grid_bfs_frontier_queue_unit gbfq_chk u_gbfq_chk (.*);
